>>> rtl/core/hes_pkg.sv
// shared types and constants for the 1-d ftcs heat equation solver core
// no dependencies
package hes_pkg;

  localparam int MAX_POINTS_DEF = 64;

  localparam int SAMPLE_W = 16;
  localparam int RATIO_W  = 16;
  localparam int STEPS_W  = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_RATIO = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEPS      = 2'd1;

  localparam logic [RATIO_W-1:0] RATIO_RESET = 16'd16384;
  localparam logic [STEPS_W-1:0] STEPS_RESET = 10'd1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PREP,
    ST_STEP,
    ST_OUT_RD,
    ST_OUT_WAIT,
    ST_OUT_SHOW
  } state_t;

endpackage

>>> rtl/core/hes_step_unit.sv
// shared update unit: three-point window, r*laplacian multiply, rounding and saturation
// depends on hes_pkg
module hes_step_unit #(
  parameter int MAX_POINTS = hes_pkg::MAX_POINTS_DEF,
  localparam int ADDR_W = $clog2(MAX_POINTS)
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [hes_pkg::RATIO_W-1:0]         ratio,
  input  logic                                in_valid,
  input  logic signed [hes_pkg::SAMPLE_W-1:0] in_data,
  input  logic [ADDR_W-1:0]                   in_idx,
  output logic                                busy,
  output logic                                wr_en,
  output logic [ADDR_W-1:0]                   wr_addr,
  output logic signed [hes_pkg::SAMPLE_W-1:0] wr_data
);

  logic signed [15:0] w_left, w_mid, w_right;
  logic               win_valid;
  logic [ADDR_W-1:0]  win_idx;

  logic               prod_valid;
  logic signed [35:0] prod;
  logic signed [15:0] prod_c;
  logic [ADDR_W-1:0]  prod_idx;

  logic signed [18:0] lap;
  logic signed [35:0] prod_next;
  logic signed [35:0] rounded;
  logic signed [19:0] delta;
  logic signed [19:0] sum;

  // left + right - 2*centre, exact in 19 bits
  assign lap = $signed({{3{w_left[15]}}, w_left}) + $signed({{3{w_right[15]}}, w_right})
             - $signed({{2{w_mid[15]}}, w_mid, 1'b0});
  assign prod_next = $signed({1'b0, ratio}) * lap;

  // round half up, then floor shift back to q1.14
  assign rounded = prod + 36'sd32768;
  assign delta   = rounded[35:16];
  assign sum     = $signed({{4{prod_c[15]}}, prod_c}) + delta;

  always_ff @(posedge clk) begin
    if (rst) begin
      win_valid  <= 1'b0;
      prod_valid <= 1'b0;
    end else begin
      win_valid  <= in_valid && (in_idx >= ADDR_W'(2));
      prod_valid <= win_valid;
    end
    if (in_valid) begin
      w_left  <= w_mid;
      w_mid   <= w_right;
      w_right <= in_data;
      win_idx <= in_idx - ADDR_W'(1);
    end
    prod     <= prod_next;
    prod_c   <= w_mid;
    prod_idx <= win_idx;
  end

  always_comb begin
    if (sum > 20'sd32767) begin
      wr_data = 16'sh7fff;
    end else if (sum < -20'sd32768) begin
      wr_data = -16'sh8000;
    end else begin
      wr_data = sum[15:0];
    end
  end

  assign wr_en   = prod_valid;
  assign wr_addr = prod_idx;
  assign busy    = win_valid || prod_valid;

endmodule

>>> rtl/core/heat_equation_ftcs_solver_core.sv
// top level of the 1-d ftcs heat equation solver: sequencer, ping-pong profile memories
// depends on hes_pkg and hes_step_unit
// load: in_ready stays high in the load state, so sample beats are never stalled;
// each time step streams the points through the single memory read port into the
// shared multiply unit one point per cycle; output: each point passes through the
// out_rd, out_wait and out_show states and waits in out_show for out_ready; reset
// clears control and config to defaults, the profile memories are not cleared
module heat_equation_ftcs_solver_core #(
  parameter int MAX_POINTS = hes_pkg::MAX_POINTS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [hes_pkg::SAMPLE_W-1:0]   sample,
  input  logic                                  last,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [hes_pkg::SAMPLE_W-1:0]   value,
  output logic                                  last_res,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [hes_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [hes_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int ADDR_W = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  hes_pkg::state_t state, state_next;

  logic [hes_pkg::RATIO_W-1:0] diffusion_ratio;
  logic [hes_pkg::STEPS_W-1:0] time_steps;
  logic [hes_pkg::STEPS_W-1:0] steps_left;
  logic [CNT_W-1:0]            count;
  logic [CNT_W-1:0]            rd_idx;
  logic [ADDR_W-1:0]           rd_j;
  logic                        rv;
  logic                        src_sel;
  logic signed [15:0]          value_reg;
  logic                        last_reg;

  logic signed [15:0] profile_a [MAX_POINTS];
  logic signed [15:0] profile_b [MAX_POINTS];
  logic signed [15:0] rdata_a, rdata_b, rdata_sel, rdata_mask;

  logic               in_acc, out_acc, issue, step_done, load_wr;
  logic [ADDR_W-1:0]  raddr;
  logic               su_busy, su_wr_en;
  logic [ADDR_W-1:0]  su_wr_addr;
  logic signed [15:0] su_wr_data;
  logic               wr_a, wr_b;
  logic [ADDR_W-1:0]  waddr;
  logic signed [15:0] wdata;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign load_wr = in_acc && (count < CNT_W'(MAX_POINTS));
  assign issue   = (state == hes_pkg::ST_STEP) && (rd_idx < count);
  assign raddr   = rd_idx[ADDR_W-1:0];

  assign cfg_ready = (state == hes_pkg::ST_LOAD);
  assign value     = value_reg;
  assign last_res  = last_reg;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    step_done  = 1'b0;
    case (state)
      hes_pkg::ST_LOAD: begin
        in_ready = 1'b1;
        if (in_valid && last) state_next = hes_pkg::ST_PREP;
      end
      hes_pkg::ST_PREP: begin
        if (steps_left == '0 || count < CNT_W'(3)) state_next = hes_pkg::ST_OUT_RD;
        else state_next = hes_pkg::ST_STEP;
      end
      hes_pkg::ST_STEP: begin
        if (rd_idx == count && !rv && !su_busy) begin
          step_done = 1'b1;
          if (steps_left == hes_pkg::STEPS_W'(1)) state_next = hes_pkg::ST_OUT_RD;
        end
      end
      hes_pkg::ST_OUT_RD:   state_next = hes_pkg::ST_OUT_WAIT;
      hes_pkg::ST_OUT_WAIT: state_next = hes_pkg::ST_OUT_SHOW;
      hes_pkg::ST_OUT_SHOW: begin
        out_valid = 1'b1;
        if (out_ready) state_next = last_reg ? hes_pkg::ST_LOAD : hes_pkg::ST_OUT_RD;
      end
      default: state_next = hes_pkg::ST_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= hes_pkg::ST_LOAD;
    else state <= state_next;
  end

  // configuration, taken only while idle
  always_ff @(posedge clk) begin
    if (rst) begin
      diffusion_ratio <= hes_pkg::RATIO_RESET;
      time_steps      <= hes_pkg::STEPS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hes_pkg::REG_DIFFUSION_RATIO: diffusion_ratio <= cfg_data[hes_pkg::RATIO_W-1:0];
        hes_pkg::REG_TIME_STEPS:      time_steps      <= cfg_data[hes_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      rd_idx  <= '0;
      rv      <= 1'b0;
      src_sel <= 1'b0;
    end else begin
      rv <= issue;
      if (load_wr) count <= count + CNT_W'(1);
      if (in_acc && last) steps_left <= time_steps;
      if (state == hes_pkg::ST_PREP) rd_idx <= '0;
      if (issue) rd_idx <= rd_idx + CNT_W'(1);
      if (step_done) begin
        rd_idx     <= '0;
        src_sel    <= ~src_sel;
        steps_left <= steps_left - hes_pkg::STEPS_W'(1);
      end
      if (out_acc) begin
        if (last_reg) count <= '0;
        else rd_idx <= rd_idx + CNT_W'(1);
      end
    end
  end

  // ends of the profile always read as zero
  assign rdata_sel  = src_sel ? rdata_b : rdata_a;
  assign rdata_mask = (rd_j == '0 || CNT_W'(rd_j) == count - CNT_W'(1)) ? 16'sd0 : rdata_sel;

  always_ff @(posedge clk) begin
    rd_j <= raddr;
    if (state == hes_pkg::ST_OUT_WAIT) begin
      value_reg <= rdata_mask;
      last_reg  <= (rd_idx == count - CNT_W'(1));
    end
  end

  // loads go to the source buffer, step results to the other one
  assign wr_a  = (load_wr && !src_sel) || (su_wr_en && src_sel);
  assign wr_b  = (load_wr && src_sel) || (su_wr_en && !src_sel);
  assign waddr = load_wr ? count[ADDR_W-1:0] : su_wr_addr;
  assign wdata = load_wr ? sample : su_wr_data;

  always_ff @(posedge clk) begin
    if (wr_a) profile_a[waddr] <= wdata;
    rdata_a <= profile_a[raddr];
  end

  always_ff @(posedge clk) begin
    if (wr_b) profile_b[waddr] <= wdata;
    rdata_b <= profile_b[raddr];
  end

  hes_step_unit #(
    .MAX_POINTS(MAX_POINTS)
  ) u_step (
    .clk      (clk),
    .rst      (rst),
    .ratio    (diffusion_ratio),
    .in_valid (rv),
    .in_data  (rdata_mask),
    .in_idx   (rd_j),
    .busy     (su_busy),
    .wr_en    (su_wr_en),
    .wr_addr  (su_wr_addr),
    .wr_data  (su_wr_data)
  );

endmodule
